/* rtl/line_follow_pid_filtered_assert.svh */
// Assertion macros for the line follower PID block
`ifndef LINE_FOLLOW_PID_FILTERED_ASSERT_SVH
`define LINE_FOLLOW_PID_FILTERED_ASSERT_SVH

// same-cycle implication
`define LFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lfp_pkg.sv */
// Shared types and constants for the line follower PID block
package lfp_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgAddrW-1:0] CFG_TARGET = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_GAIN_P = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_GAIN_I = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_GAIN_D = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_ALPHA  = 3'd4;

  localparam logic [7:0]  TARGET_RST = 8'd76;
  localparam logic [11:0] GAIN_P_RST = 12'd973;
  localparam logic [11:0] GAIN_I_RST = 12'd0;
  localparam logic [11:0] GAIN_D_RST = 12'd307;
  localparam logic [8:0]  ALPHA_RST  = 9'd51;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE = 4'd0;
  localparam op_t OP_LOAD = 4'd1;
  localparam op_t OP_P    = 4'd2;
  localparam op_t OP_I    = 4'd3;
  localparam op_t OP_D    = 4'd4;
  localparam op_t OP_RAW  = 4'd5;
  localparam op_t OP_FA   = 4'd6;
  localparam op_t OP_FB   = 4'd7;
  localparam op_t OP_OUT  = 4'd8;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } st_t;

endpackage

/* rtl/line_follow_pid_filtered.sv */
// Top level of the line follower PID controller with output low-pass filter
//
// Input stream in_*: one line position per request (in_tdata[7:0]).
// Output stream out_*: one filtered steering correction per request,
// 16-bit two's complement in out_tdata[15:0].
// Configuration: cfg_we with cfg_addr selects target, P, I, D gain or
// filter alpha; write only while no request is in flight.
// Sequence: accepting a request loads it, then the controller steps through
// P, I, D, RAW, FA, FB and OUT; OUT waits for a free output register and
// loads the result into it. All five products of a request go through one
// shared 13x24 multiplier. A new request is taken only after OUT, and may be
// taken while that result still waits in the output register; if the receiver
// stalls, a second result stays in the accumulator until that register frees.
// Reset: settings return to their defaults, error sum, last error and last
// filtered value clear to zero, and the output stream goes idle.
module line_follow_pid_filtered
  import lfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] sensed position
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata   // [15:0] drive_correction
);

`include "line_follow_pid_filtered_assert.svh"

  cmd_t cmd;
  st_t  st;

  lfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lfp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_pos     (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `LFP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `LFP_ASSERT_NOW(a_steps_only_busy, cmd.op != OP_NONE && cmd.op != OP_LOAD, !in_tready, "step while idle")
  `LFP_ASSERT_NOW(a_load_is_accept, cmd.op == OP_LOAD, in_tvalid && in_tready, "load without request")
  `LFP_ASSERT_NEXT(a_out_after_commit, cmd.op == OP_OUT, out_tvalid, "result not presented")

endmodule

/* rtl/lfp_ctrl.sv */
// Sequencer that steps one request through the shared multiplier
module lfp_ctrl
  import lfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_P    = 3'd1;
  localparam logic [2:0] ST_I    = 3'd2;
  localparam logic [2:0] ST_D    = 3'd3;
  localparam logic [2:0] ST_RAW  = 3'd4;
  localparam logic [2:0] ST_FA   = 3'd5;
  localparam logic [2:0] ST_FB   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_P;
        end
      end
      ST_P: begin
        cmd.op    = OP_P;
        state_nxt = ST_I;
      end
      ST_I: begin
        cmd.op    = OP_I;
        state_nxt = ST_D;
      end
      ST_D: begin
        cmd.op    = OP_D;
        state_nxt = ST_RAW;
      end
      ST_RAW: begin
        cmd.op    = OP_RAW;
        state_nxt = ST_FA;
      end
      ST_FA: begin
        cmd.op    = OP_FA;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        cmd.op    = OP_FB;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!st.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lfp_dp.sv */
// Datapath: settings, controller state, shared multiplier and output register
module lfp_dp
  import lfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic [7:0]          in_pos,
  input  cmd_t                cmd,
  output st_t                 st,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata
);

  localparam logic [3:0] RAW_SHIFT  = 4'd9;
  localparam logic [3:0] FILT_SHIFT = 4'd8;

  logic [7:0]  target_r;
  logic [11:0] gain_p_r;
  logic [11:0] gain_i_r;
  logic [11:0] gain_d_r;
  logic [8:0]  alpha_r;

  logic signed [23:0] error_sum_r;
  logic signed [8:0]  prev_err_r;
  logic signed [15:0] prev_filt_r;
  logic signed [9:0]  diff_r;
  logic signed [38:0] acc_r;
  logic signed [15:0] raw_r;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  logic signed [8:0]  err_w;
  logic signed [24:0] sum_w;
  logic signed [23:0] sum_sat;
  logic signed [9:0]  diff_w;
  logic [8:0]         alpha_c;
  logic [8:0]         alpha_inv;
  logic signed [12:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [36:0] prod;
  logic signed [38:0] prod_x1;
  logic signed [38:0] prod_x2;
  logic signed [15:0] raw_w;
  logic signed [15:0] filt_w;

  function automatic logic signed [15:0] trunc_sat(input logic signed [38:0] v,
                                                   input logic [3:0] sh);
    logic signed [38:0] bias;
    logic signed [38:0] q;
    bias = v[38] ? ((39'sd1 <<< sh) - 39'sd1) : 39'sd0;
    q    = (v + bias) >>> sh;
    if (q > 39'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -39'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  always_comb begin
    err_w  = $signed({1'b0, target_r}) - $signed({1'b0, in_pos});
    sum_w  = $signed({error_sum_r[23], error_sum_r}) + $signed({{16{err_w[8]}}, err_w});
    if (sum_w > 25'sd8388607) begin
      sum_sat = 24'sh7FFFFF;
    end else if (sum_w < -25'sd8388608) begin
      sum_sat = 24'sh800000;
    end else begin
      sum_sat = sum_w[23:0];
    end
    diff_w = $signed({err_w[8], err_w}) - $signed({prev_err_r[8], prev_err_r});
  end

  assign alpha_c   = (alpha_r > 9'd256) ? 9'd256 : alpha_r;
  assign alpha_inv = 9'd256 - alpha_c;

  always_comb begin
    mul_a = 13'sd0;
    mul_b = 24'sd0;
    case (cmd.op)
      OP_P: begin
        mul_a = $signed({1'b0, gain_p_r});
        mul_b = {{15{prev_err_r[8]}}, prev_err_r};
      end
      OP_I: begin
        mul_a = $signed({1'b0, gain_i_r});
        mul_b = error_sum_r;
      end
      OP_D: begin
        mul_a = $signed({1'b0, gain_d_r});
        mul_b = {{14{diff_r[9]}}, diff_r};
      end
      OP_FA: begin
        mul_a = $signed({4'd0, alpha_c});
        mul_b = {{8{raw_r[15]}}, raw_r};
      end
      OP_FB: begin
        mul_a = $signed({4'd0, alpha_inv});
        mul_b = {{8{prev_filt_r[15]}}, prev_filt_r};
      end
      default: begin
        mul_a = 13'sd0;
        mul_b = 24'sd0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_x1 = {{2{prod[36]}}, prod};
  assign prod_x2 = {prod[36], prod, 1'b0};
  assign raw_w   = trunc_sat(acc_r, RAW_SHIFT);
  assign filt_w  = trunc_sat(acc_r, FILT_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      alpha_r  <= ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TARGET: target_r <= cfg_wdata[7:0];
        CFG_GAIN_P: gain_p_r <= cfg_wdata;
        CFG_GAIN_I: gain_i_r <= cfg_wdata;
        CFG_GAIN_D: gain_d_r <= cfg_wdata;
        CFG_ALPHA:  alpha_r  <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= 24'sd0;
      prev_err_r  <= 9'sd0;
      prev_filt_r <= 16'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          error_sum_r <= sum_sat;
          prev_err_r  <= err_w;
        end
        OP_OUT: begin
          prev_filt_r <= filt_w;
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: diff_r     <= diff_w;
      OP_P:    acc_r      <= prod_x2;
      OP_I:    acc_r      <= acc_r + prod_x1;
      OP_D:    acc_r      <= acc_r + prod_x2;
      OP_RAW:  raw_r      <= raw_w;
      OP_FA:   acc_r      <= prod_x1;
      OP_FB:   acc_r      <= acc_r + prod_x1;
      OP_OUT:  out_data_r <= filt_w;
      default: begin
      end
    endcase
  end

  assign st.out_busy = out_valid_r & ~out_tready;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

endmodule
